FILE: hdl/lfsr_noise_tone_sound_mixer_top_macros.svh
// Assertion macros shared by the sound mixer RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef LFSR_NOISE_TONE_SOUND_MIXER_TOP_MACROS_SVH
`define LFSR_NOISE_TONE_SOUND_MIXER_TOP_MACROS_SVH

// same-cycle implication
`define LNTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LNTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/lnts_pkg.sv
// Package for the LFSR noise / tone sound mixer: request codes, register
// indexes, constants, sine and volume tables, LFSR step. No dependencies.
package lnts_pkg;

    localparam int MAX_STEPS   = 96;
    localparam int SINE_POINTS = 64;
    localparam int SINE_BITS   = $clog2(SINE_POINTS);

    localparam int RATE_W  = 23;
    localparam int PHASE_W = 48;
    localparam int OVER_W  = 32;
    localparam int LFSR_W  = 16;
    localparam int LEVEL_W = 24;
    localparam int CFG_W   = RATE_W;
    localparam int IDX_W   = 2;
    localparam int MIX_W   = 11;

    typedef enum logic [1:0] {
        REQ_SAMPLE     = 2'd0,
        REQ_CONTROL    = 2'd1,
        REQ_LFSR_RESET = 2'd2,
        REQ_UNUSED     = 2'd3
    } t_req;

    localparam logic [IDX_W-1:0] REG_RATE_STEP     = 2'd0;
    localparam logic [IDX_W-1:0] REG_WIDE_OUTPUT   = 2'd1;
    localparam logic [IDX_W-1:0] REG_SIGNED_OUTPUT = 2'd2;

    localparam logic [RATE_W-1:0] RATE_RESET = 23'd1141307;

    localparam logic [15:0] TAP_HI      = 16'h4000;
    localparam logic [15:0] TAP_LO      = 16'h0040;
    localparam logic [15:0] HALF_WIDE   = 16'h8000;
    localparam logic [7:0]  HALF_NARROW = 8'h80;

    localparam logic [7:0] SINE_TAB [SINE_POINTS] = '{
        8'd128, 8'd140, 8'd153, 8'd165, 8'd177, 8'd188, 8'd199, 8'd209,
        8'd218, 8'd226, 8'd234, 8'd240, 8'd245, 8'd250, 8'd253, 8'd254,
        8'd255, 8'd254, 8'd253, 8'd250, 8'd245, 8'd240, 8'd234, 8'd226,
        8'd218, 8'd209, 8'd199, 8'd188, 8'd177, 8'd165, 8'd153, 8'd140,
        8'd128, 8'd116, 8'd103, 8'd91,  8'd79,  8'd68,  8'd57,  8'd47,
        8'd38,  8'd30,  8'd22,  8'd16,  8'd11,  8'd6,   8'd3,   8'd2,
        8'd1,   8'd2,   8'd3,   8'd6,   8'd11,  8'd16,  8'd22,  8'd30,
        8'd38,  8'd47,  8'd57,  8'd68,  8'd79,  8'd91,  8'd103, 8'd116
    };

    function automatic logic [7:0] sine_at(input logic [SINE_BITS-1:0] idx);
        return SINE_TAB[idx];
    endfunction

    function automatic logic [7:0] vol_level(input logic [2:0] vol);
        logic [7:0] lvl;
        case (vol)
            3'd0:    lvl = 8'h00;
            3'd1:    lvl = 8'h20;
            3'd2:    lvl = 8'h40;
            3'd3:    lvl = 8'h60;
            3'd4:    lvl = 8'h80;
            3'd5:    lvl = 8'ha0;
            3'd6:    lvl = 8'hc0;
            default: lvl = 8'hff;
        endcase
        return lvl;
    endfunction

    // XNOR feedback from bits 14 and 6; all ones locks
    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
        logic fb;
        fb = ((v & TAP_HI) != '0) == ((v & TAP_LO) != '0);
        return {v[LFSR_W-2:0], fb};
    endfunction

endpackage

FILE: hdl/lnts_smooth.sv
// One smoothing step: level moves 1/128 of the way toward target.
// Uses lnts_pkg for widths.
module lnts_smooth (
    input  logic [lnts_pkg::LEVEL_W-1:0] i_level,
    input  logic [lnts_pkg::LEVEL_W-1:0] i_target,
    output logic [lnts_pkg::LEVEL_W-1:0] o_level
);

    logic [lnts_pkg::LEVEL_W-1:0] up_diff;
    logic [lnts_pkg::LEVEL_W:0]   dn_diff;

    always_comb begin
        up_diff = i_target - i_level;
        // falling side rounds the step up so the level can reach the target
        dn_diff = {1'b0, i_level - i_target} + (lnts_pkg::LEVEL_W+1)'(127);
        if (i_target >= i_level) begin
            o_level = i_level + (up_diff >> 7);
        end else begin
            o_level = i_level - lnts_pkg::LEVEL_W'(dn_diff >> 7);
        end
    end

endmodule

FILE: hdl/lfsr_noise_tone_sound_mixer_top.sv
// Sound mixer top level: request sequencer, smoothing loop, mixer, output register.
// Depends on lnts_pkg, lnts_smooth and lfsr_noise_tone_sound_mixer_top_macros.svh.
//
// Requests enter on i_in_valid / o_in_ready with i_req_type and i_control_byte.
// A control write or LFSR reset request completes in the accept cycle and
// gives no sample. A sample request gives one o_sample_word on o_out_valid /
// i_out_ready.
// A sample request runs the smoothing step once for each oversample step passed
// since the last sample, capped at MAX_STEPS_PER_SAMPLE, then mixes and loads
// the output register. The smoothing step unit is reused once per cycle;
// o_in_ready is low meanwhile.
// The sample sits in an output register: a stalled receiver does not block
// the next request, only the final load of the following sample waits.
// Registers on i_cfg_we / i_cfg_index / i_cfg_data: 0 rate step (7.16),
// 1 wide output, 2 signed output. Write them only while idle.
// Reset (synchronous, active low) clears phase, LFSR, noise and enables and
// loads rate step 1141307, wide output on, signed output off.
`include "lfsr_noise_tone_sound_mixer_top_macros.svh"

module lfsr_noise_tone_sound_mixer_top #(
    parameter int MAX_STEPS_PER_SAMPLE = lnts_pkg::MAX_STEPS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [lnts_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [lnts_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_req_type,
    input  logic [7:0]                   i_control_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [15:0]                  o_sample_word
);

    localparam int STEP_W = $clog2(MAX_STEPS_PER_SAMPLE + 1);
    localparam logic [STEP_W-1:0] STEP_CAP = STEP_W'(MAX_STEPS_PER_SAMPLE);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SMOOTH,
        S_MIX
    } t_state;

    t_state r_state;

    logic [lnts_pkg::RATE_W-1:0]  r_rate_step;
    logic                         r_wide;
    logic                         r_signed;
    logic [lnts_pkg::PHASE_W-1:0] r_phase;
    logic [lnts_pkg::OVER_W-1:0]  r_last;
    logic [lnts_pkg::LFSR_W-1:0]  r_lfsr;
    logic [lnts_pkg::LEVEL_W-1:0] r_target;
    logic [lnts_pkg::LEVEL_W-1:0] r_level;
    logic [2:0]                   r_volume;
    logic                         r_tone_low;
    logic                         r_tone_high;
    logic                         r_blast;
    logic [STEP_W-1:0]            r_steps;
    logic [7:0]                   r_over_lo;
    logic                         r_out_valid;
    logic [15:0]                  r_sample_word;

    logic [lnts_pkg::OVER_W-1:0]  over;
    logic [lnts_pkg::OVER_W-1:0]  step_diff;
    logic [STEP_W-1:0]            n_steps;
    logic [lnts_pkg::LFSR_W-1:0]  n_lfsr;
    logic [lnts_pkg::LFSR_W-1:0]  lfsr_ahead;
    logic [lnts_pkg::LEVEL_W-1:0] n_target;
    logic [lnts_pkg::LEVEL_W-1:0] n_level;
    logic [lnts_pkg::MIX_W-1:0]   mix;
    logic [15:0]                  n_word;
    logic [7:0]                   narrow;
    logic                         in_fire;
    logic                         out_fire;
    logic                         load_out;

    // no request is taken while reset is held
    assign o_in_ready    = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid   = r_out_valid;
    assign o_sample_word = r_sample_word;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = r_out_valid && i_out_ready;
    assign load_out = (r_state == S_MIX) && (!r_out_valid || i_out_ready);

    assign over       = r_phase[lnts_pkg::PHASE_W-1:16];
    assign step_diff  = over - r_last;
    assign n_steps    = (step_diff > lnts_pkg::OVER_W'(MAX_STEPS_PER_SAMPLE))
                        ? STEP_CAP : step_diff[STEP_W-1:0];
    assign n_lfsr     = lnts_pkg::lfsr_next(r_lfsr);
    assign lfsr_ahead = lnts_pkg::lfsr_next(n_lfsr);
    assign n_target   = ((lfsr_ahead & lnts_pkg::TAP_HI) != '0)
                        ? {lnts_pkg::vol_level(r_volume), 16'h0000} : '0;

    lnts_smooth u_smooth (
        .i_level  (r_level),
        .i_target (r_target),
        .o_level  (n_level)
    );

    always_comb begin
        mix = {2'b00, r_level[23:16], 1'b0};
        if (r_tone_low) begin
            mix = mix + lnts_pkg::MIX_W'(lnts_pkg::sine_at(r_over_lo[7:2]));
        end
        if (r_tone_high) begin
            mix = mix + lnts_pkg::MIX_W'(lnts_pkg::sine_at(r_over_lo[6:1]));
        end
        if (r_blast) begin
            mix = mix + lnts_pkg::MIX_W'(r_level[23:14]);
        end
        narrow = mix[10:3];
        if (r_wide) begin
            n_word = {mix, 5'b00000};
            if (r_signed) begin
                n_word = n_word - lnts_pkg::HALF_WIDE;
            end
        end else begin
            if (r_signed) begin
                narrow = narrow - lnts_pkg::HALF_NARROW;
            end
            n_word = {8'h00, narrow};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rate_step <= lnts_pkg::RATE_RESET;
            r_wide      <= 1'b1;
            r_signed    <= 1'b0;
            r_phase     <= '0;
            r_last      <= '0;
            r_lfsr      <= '0;
            r_target    <= '0;
            r_level     <= '0;
            r_volume    <= '0;
            r_tone_low  <= 1'b0;
            r_tone_high <= 1'b0;
            r_blast     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lnts_pkg::REG_RATE_STEP:     r_rate_step <= i_cfg_data;
                    lnts_pkg::REG_WIDE_OUTPUT:   r_wide      <= i_cfg_data[0];
                    lnts_pkg::REG_SIGNED_OUTPUT: r_signed    <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // a load in the same cycle keeps the output valid
            if (out_fire && !load_out) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        case (lnts_pkg::t_req'(i_req_type))
                            lnts_pkg::REQ_SAMPLE: begin
                                if (r_last[31:6] != over[31:6]) begin
                                    r_lfsr   <= n_lfsr;
                                    r_target <= n_target;
                                end
                                r_steps   <= n_steps;
                                r_over_lo <= over[7:0];
                                r_last    <= over;
                                r_phase   <= r_phase
                                             + lnts_pkg::PHASE_W'(r_rate_step);
                                r_state   <= (n_steps == '0) ? S_MIX : S_SMOOTH;
                            end
                            lnts_pkg::REQ_CONTROL: begin
                                r_volume    <= i_control_byte[2:0];
                                r_blast     <= i_control_byte[3];
                                r_tone_low  <= i_control_byte[4];
                                r_tone_high <= i_control_byte[5];
                            end
                            lnts_pkg::REQ_LFSR_RESET: begin
                                r_lfsr <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SMOOTH: begin
                    r_level <= n_level;
                    r_steps <= r_steps - STEP_W'(1);
                    if (r_steps == STEP_W'(1)) begin
                        r_state <= S_MIX;
                    end
                end
                S_MIX: begin
                    if (load_out) begin
                        r_sample_word <= n_word;
                        r_out_valid   <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `LNTS_ASSERT_NOW(a_step_range, r_state == S_SMOOTH,
        (r_steps != '0) && (r_steps <= STEP_CAP), "smoothing count out of range")
    `LNTS_ASSERT_NEXT(a_sample_busy,
        in_fire && (i_req_type == lnts_pkg::REQ_SAMPLE),
        !o_in_ready, "ready right after a sample request")
    `LNTS_ASSERT_NEXT(a_narrow_high_zero, load_out && !r_wide,
        o_sample_word[15:8] == 8'h00, "narrow sample has upper byte set")
    `LNTS_ASSERT_NOW(a_mix_blocked, (r_state == S_MIX) && r_out_valid && !i_out_ready,
        !load_out, "sample loaded over a pending one")

endmodule
